FILE: design/longest_prefix_route_lookup_assert.svh
// Assertion macros for the longest prefix route lookup block
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPRL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LPRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lprl_pkg.sv
// Package for the longest prefix route lookup: sizes, codes, entry and state types
package lprl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PORT_BITS   = 4;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_BITS   = 32;
    localparam int CFG_W       = 7;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [ADDR_BITS-1:0] mask;
        logic [ADDR_BITS-1:0] gateway;
        logic [PORT_BITS-1:0] port;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

endpackage

FILE: design/lprl_ram.sv
// Generic single write port, single read port RAM with registered read data
module lprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/longest_prefix_route_lookup.sv
// Top level of the longest prefix route lookup: sequencer, table RAM, shared compare unit
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  item in   | start / busy              | mode, entry_index, entry_prefix, entry_mask,
//            |                           | entry_next_hop, entry_port, dest_ip
//  result    | route_valid (one cycle)   | route_found, route_index, route_next_hop,
//            |                           | route_port, route_mask
//  config    | cfg_valid / cfg_ready     | table_size
//
// A write item leaves busy low.
// A lookup holds busy from its accepting edge through the scan of table_size entries
// (table_size saturated at table depth): one table RAM read per cycle, one compare
// unit, then one cycle with route_valid high.
// rst_n clears control state and table_size; table contents are undefined until written.
// Results cannot be stalled; cfg_ready is always high.
module longest_prefix_route_lookup
    import lprl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [5:0]            entry_index,
    input  logic [ADDR_BITS-1:0]  entry_prefix,
    input  logic [ADDR_BITS-1:0]  entry_mask,
    input  logic [ADDR_BITS-1:0]  entry_next_hop,
    input  logic [PORT_BITS-1:0]  entry_port,
    input  logic [ADDR_BITS-1:0]  dest_ip,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      table_size,
    output logic                  route_valid,
    output logic                  route_found,
    output logic [5:0]            route_index,
    output logic [ADDR_BITS-1:0]  route_next_hop,
    output logic [PORT_BITS-1:0]  route_port,
    output logic [ADDR_BITS-1:0]  route_mask
);

    `include "longest_prefix_route_lookup_assert.svh"

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     table_size_reg;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [ADDR_BITS-1:0] dest_reg, dest_next;
    logic                 best_found_reg, best_found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [ADDR_BITS-1:0] best_hop_reg, best_hop_next;
    logic [PORT_BITS-1:0] best_port_reg, best_port_next;
    logic [ADDR_BITS-1:0] best_mask_reg, best_mask_next;

    logic                 accept;
    logic                 wr_en;
    logic                 rd_en;
    logic [CNT_W-1:0]     limit_sat;
    entry_t               wr_entry;
    entry_t               rd_entry;
    logic                 hit;
    logic                 better;

    assign accept    = start && !busy;
    assign wr_en     = accept && (mode == MODE_WRITE);
    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg < limit_reg);
    assign cfg_ready = 1'b1;

    assign limit_sat = (table_size_reg > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(table_size_reg);

    assign wr_entry.prefix  = entry_prefix;
    assign wr_entry.mask    = entry_mask;
    assign wr_entry.gateway = entry_next_hop;
    assign wr_entry.port    = entry_port;

    lprl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    // shared compare unit: match test and mask ranking
    assign hit    = ((dest_reg & rd_entry.mask) == rd_entry.prefix);
    assign better = !best_found_reg || (rd_entry.mask > best_mask_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !pend_reg)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = issue_reg[IDX_W-1:0];
        dest_next       = dest_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_hop_next   = best_hop_reg;
        best_port_next  = best_port_reg;
        best_mask_next  = best_mask_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_LOOKUP))
                begin
                    limit_next      = limit_sat;
                    issue_next      = '0;
                    dest_next       = dest_ip;
                    best_found_next = 1'b0;
                    best_idx_next   = '0;
                    best_hop_next   = '0;
                    best_port_next  = '0;
                    best_mask_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg && hit && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pend_idx_reg;
                    best_hop_next   = rd_entry.gateway;
                    best_port_next  = rd_entry.port;
                    best_mask_next  = rd_entry.mask;
                end
            end
            ST_REPORT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        route_valid    = (state_reg == ST_REPORT);
        route_found    = best_found_reg;
        route_index    = 6'(best_idx_reg);
        route_next_hop = best_hop_reg;
        route_port     = best_port_reg;
        route_mask     = best_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            table_size_reg <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            best_found_reg <= best_found_next;
            if (cfg_valid && cfg_ready)
            begin
                table_size_reg <= table_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        dest_reg      <= dest_next;
        best_idx_reg  <= best_idx_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        best_mask_reg <= best_mask_next;
    end

    `LPRL_ASSERT_NEXT(a_result_frees, route_valid, !busy && !route_valid,
        "result strobe not followed by idle")
    `LPRL_ASSERT_NEXT(a_lookup_busy, accept && (mode == MODE_LOOKUP), busy,
        "lookup item did not start a scan")
    `LPRL_ASSERT_NEXT(a_write_quiet, accept && (mode == MODE_WRITE), !busy && !route_valid,
        "write item caused activity")
    `LPRL_ASSERT_IMPLY(a_miss_zero, route_valid && !route_found,
        (route_index == 6'd0) && (route_mask == '0) && (route_next_hop == '0)
        && (route_port == '0),
        "miss result carries nonzero fields")

endmodule

FILE: tb/longest_prefix_route_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for longest_prefix_route_lookup: directed and random items checked by a route predictor
module longest_prefix_route_lookup_tb;
    import lprl_pkg::*;

    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     index;
        logic [ADDR_BITS-1:0] gateway;
        logic [PORT_BITS-1:0] port;
        logic [ADDR_BITS-1:0] mask;
    } route_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 start          = 1'b0;
    logic                 mode           = MODE_WRITE;
    logic [IDX_W-1:0]     entry_index    = '0;
    logic [ADDR_BITS-1:0] entry_prefix   = '0;
    logic [ADDR_BITS-1:0] entry_mask     = '0;
    logic [ADDR_BITS-1:0] entry_next_hop = '0;
    logic [PORT_BITS-1:0] entry_port     = '0;
    logic [ADDR_BITS-1:0] dest_ip        = '0;
    logic                 cfg_valid      = 1'b0;
    logic [CFG_W-1:0]     table_size     = '0;
    logic                 busy;
    logic                 cfg_ready;
    logic                 route_valid;
    logic                 route_found;
    logic [IDX_W-1:0]     route_index;
    logic [ADDR_BITS-1:0] route_next_hop;
    logic [PORT_BITS-1:0] route_port;
    logic [ADDR_BITS-1:0] route_mask;

    // predictor state
    entry_t           fib [TABLE_DEPTH];
    logic [CFG_W-1:0] fib_size = '0;
    route_t           pending_routes [$];

    // stimulus-side view of the table
    entry_t               plan [TABLE_DEPTH];
    int                   plan_span = 0;
    logic [ADDR_BITS-1:0] route_bases [4];
    int                   send_idle_pct = 0;

    int failures     = 0;
    int quiet_cycles = 0;

    longest_prefix_route_lookup dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .entry_index    (entry_index),
        .entry_prefix   (entry_prefix),
        .entry_mask     (entry_mask),
        .entry_next_hop (entry_next_hop),
        .entry_port     (entry_port),
        .dest_ip        (dest_ip),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .table_size     (table_size),
        .route_valid    (route_valid),
        .route_found    (route_found),
        .route_index    (route_index),
        .route_next_hop (route_next_hop),
        .route_port     (route_port),
        .route_mask     (route_mask)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= SHOW_LIMIT)
            $display("%s", msg);
    endfunction

    // longest mask wins, lowest slot on a tie
    function automatic route_t longest_match(input logic [ADDR_BITS-1:0] dest);
        route_t r;
        int     span;
        r    = '0;
        span = (fib_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(fib_size);
        for (int i = 0; i < span; i++)
        begin
            if ((dest & fib[i].mask) == fib[i].prefix && (!r.found || fib[i].mask > r.mask))
            begin
                r.found   = 1'b1;
                r.index   = IDX_W'(i);
                r.gateway = fib[i].gateway;
                r.port    = fib[i].port;
                r.mask    = fib[i].mask;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : route_monitor
        route_t got;
        route_t want;
        if (rst_n)
        begin
            if (route_valid)
            begin
                got = '{route_found, route_index, route_next_hop, route_port, route_mask};
                if (pending_routes.size() == 0)
                    note_failure($sformatf("unexpected route result at %0t", $time));
                else
                begin
                    want = pending_routes.pop_front();
                    if (got.found !== want.found || got.index !== want.index ||
                        got.gateway !== want.gateway || got.port !== want.port ||
                        got.mask !== want.mask)
                        note_failure($sformatf({"route mismatch at %0t: expected found=%0b ",
                            "index=%0d gateway=%h port=%0d mask=%h; got found=%0b index=%0d ",
                            "gateway=%h port=%0d mask=%h"}, $time,
                            want.found, want.index, want.gateway, want.port, want.mask,
                            got.found, got.index, got.gateway, got.port, got.mask));
                end
            end
            if (start && !busy)
            begin
                if (mode == MODE_WRITE)
                    fib[entry_index] = '{prefix: entry_prefix, mask: entry_mask,
                                         gateway: entry_next_hop, port: entry_port};
                else
                    pending_routes.push_back(longest_match(dest_ip));
            end
            if (cfg_valid && cfg_ready)
                fib_size = table_size;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || route_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [ADDR_BITS-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : {ADDR_BITS{1'b1}} << (ADDR_BITS - len);
    endfunction

    // mostly nested prefixes off a few bases, some odd masks, some dead entries
    function automatic entry_t random_route();
        entry_t e;
        int     form;
        int     len;
        form      = $urandom_range(0, 99);
        len       = $urandom_range(0, 1) ? 8 * $urandom_range(1, 4) : $urandom_range(1, 32);
        e.gateway = ($urandom_range(0, 15) == 0) ? '1 : ADDR_BITS'($urandom());
        e.port    = PORT_BITS'($urandom_range(0, (1 << PORT_BITS) - 1));
        if (form < 70)
        begin
            e.mask   = prefix_mask(len);
            e.prefix = route_bases[$urandom_range(0, 3)] & e.mask;
        end
        else if (form < 85)
        begin
            e.mask   = $urandom();
            e.prefix = $urandom() & e.mask;
        end
        else
        begin
            e.mask   = $urandom();
            e.prefix = $urandom();
        end
        return e;
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_dest();
        int pick;
        int j;
        pick = $urandom_range(0, 99);
        if (pick < 75 && plan_span > 0)
        begin
            j = $urandom_range(0, plan_span - 1);
            return (plan[j].prefix & plan[j].mask) | ($urandom() & ~plan[j].mask);
        end
        if (pick < 88)
            return route_bases[$urandom_range(0, 3)] ^ ($urandom() & 32'h0000_FFFF);
        return $urandom();
    endfunction

    task automatic send_item(input logic m, input logic [IDX_W-1:0] idx, input entry_t e,
                             input logic [ADDR_BITS-1:0] dest);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        start          <= 1'b1;
        mode           <= m;
        entry_index    <= idx;
        entry_prefix   <= e.prefix;
        entry_mask     <= e.mask;
        entry_next_hop <= e.gateway;
        entry_port     <= e.port;
        dest_ip        <= dest;
        do
            @(posedge clk);
        while (busy);
        if (m == MODE_WRITE)
            plan[idx] = e;
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input entry_t e);
        send_item(MODE_WRITE, idx, e, $urandom());
    endtask

    task automatic send_lookup(input logic [ADDR_BITS-1:0] dest);
        entry_t junk;
        junk = '{$urandom(), $urandom(), $urandom(), PORT_BITS'($urandom())};
        send_item(MODE_LOOKUP, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), junk, dest);
    endtask

    // block idle: no item held, all results in, writes finished
    task automatic settle();
        start <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] v);
        settle();
        cfg_valid  <= 1'b1;
        table_size <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        plan_span = (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 99) < 20)
            send_write(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), random_route());
        else
            send_lookup(random_dest());
    endtask

    task automatic test_empty_table();
        send_lookup('0);
        send_lookup('1);
        write_table_size('0);
        send_lookup($urandom());
    endtask

    task automatic test_route_priority();
        send_write(0, '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15});
        send_write(1, '{32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 4'd0});
        send_write(2, '{32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'd1});
        send_write(3, '{32'h0A01_0100, 32'hFFFF_FF00, 32'h0A01_0101, 4'd2});
        send_write(4, '{32'h0A01_0100, 32'hFFFF_FF00, 32'h0A01_01FE, 4'd3});
        send_write(5, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0B0B_0B0B, 4'd4});
        send_write(6, '{32'h0A00_0001, 32'hFF00_00FF, 32'h0C0C_0C0C, 4'd5});
        // prefix bits outside the mask: never matches
        send_write(7, '{32'h1234_5678, 32'hFFFF_0000, 32'h0D0D_0D0D, 4'd6});
        send_write(IDX_W'(TABLE_DEPTH - 1),
                   '{32'h0A01_0105, 32'hFFFF_FFFF, 32'h0E0E_0E0E, 4'd9});
        write_table_size(1);
        send_lookup(32'h0A01_0105);
        send_lookup(32'h0000_0000);
        write_table_size(8);
        send_lookup(32'h0A01_0105);
        send_lookup(32'h0A02_0304);
        send_lookup(32'h0A01_FF01);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0A77_0001);
        send_lookup(32'h1234_5678);
        send_write(0, '{32'hC000_0000, 32'hF000_0000, 32'h0102_0304, 4'd7});
        send_lookup(32'h1234_5678);
        send_lookup(32'hC123_4567);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(IDX_W'(i), random_route());
        write_table_size('1);
        repeat (8) send_lookup(random_dest());
        write_table_size(CFG_W'(TABLE_DEPTH + 1));
        repeat (8) send_lookup(random_dest());
    endtask

    task automatic test_random_traffic();
        int               idle_plan [3] = '{12, 76, 0};
        logic [CFG_W-1:0] span_cfg;
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = idle_plan[p];
            for (int k = 0; k < 4; k++)
            begin
                case (k)
                    0:       span_cfg = CFG_W'(TABLE_DEPTH);
                    1:       span_cfg = CFG_W'($urandom_range(2, TABLE_DEPTH - 1));
                    2:       span_cfg = (p == 0) ? 7'd127 : (p == 1) ? 7'd1 : 7'd65;
                    default: span_cfg = CFG_W'($urandom_range(0, 127));
                endcase
                write_table_size(span_cfg);
                repeat (48) random_item();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            route_bases[i] = $urandom();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 12;
        test_empty_table();
        test_route_priority();
        test_full_table();
        test_random_traffic();
        settle();
        if (pending_routes.size() != 0)
            note_failure($sformatf("%0d lookups never returned a route", pending_routes.size()));
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
